>>> hw/rtl/top_source_frequency_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-source frequency table
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOP_SOURCE_FREQUENCY_TABLE_ASSERT_SVH
`define TOP_SOURCE_FREQUENCY_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define SFT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sft assertion failed");

// Check that cons holds in the cycle after ante.
`define SFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sft assertion failed");

`else

`define SFT_ASSERT(lbl, clk, rst_n, prop)
`define SFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Widths, codes and the types passed between the table cells and the control.
// ----------------------------------------------------------------------------
package sft_pkg;

	localparam int KEY_W   = 64;
	localparam int CNT_W   = 32;
	localparam int TOTAL_W = 48;
	localparam int ACT_W   = 2;
	localparam int OUT_SLOT_W = 4;
	// Slot numbers inside the chain; wide enough for the largest table (256 entries).
	localparam int SLOT_W  = 8;

	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [ACT_W-1:0] ACT_HIT     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FILL    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} sft_state_t;

	// Search token that travels down the chain, one cell per cycle.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] hit_idx;
		logic [CNT_W-1:0]  hit_cnt;
		logic              min_ok;
		logic [SLOT_W-1:0] min_idx;
		logic [CNT_W-1:0]  min_cnt;
		logic [KEY_W-1:0]  min_key;
	} sft_tok_t;

	localparam sft_tok_t TOK_INIT = '0;

	// Entry write, broadcast to all cells.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  cnt;
	} sft_wr_t;

endpackage

>>> hw/rtl/sft_cell.sv
// ----------------------------------------------------------------------------
// sft_cell
// One table entry: holds a key and its count, and refines the passing token.
// ----------------------------------------------------------------------------
module sft_cell (
	input  logic                                clk,
	input  logic [sft_pkg::KEY_W-1:0]           probe_key,
	input  logic [sft_pkg::SLOT_W-1:0]          cell_idx,
	input  logic [sft_pkg::SLOT_W:0]            used,
	input  sft_pkg::sft_wr_t                    wr,
	input  sft_pkg::sft_tok_t                   tok_in,
	output sft_pkg::sft_tok_t                   tok_out
);
	import sft_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	sft_tok_t         tok_d;
	sft_tok_t         tok_q;
	logic             filled;

	assign filled = ({1'b0, cell_idx} < used);

	always_comb begin
		tok_d = tok_in;
		if (filled && !tok_in.found) begin
			if (key_q == probe_key) begin
				tok_d.found   = 1'b1;
				tok_d.hit_idx = cell_idx;
				tok_d.hit_cnt = cnt_q;
			end else if (!tok_in.min_ok || (cnt_q < tok_in.min_cnt)) begin
				tok_d.min_ok  = 1'b1;
				tok_d.min_idx = cell_idx;
				tok_d.min_cnt = cnt_q;
				tok_d.min_key = key_q;
			end
		end
	end

	// Advance the token every cycle.
	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx)) begin
			key_q <= wr.key;
			cnt_q <= wr.cnt;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> hw/rtl/top_source_frequency_table.sv
// ----------------------------------------------------------------------------
// top_source_frequency_table
// Heavy-hitter table of packet source keys with replace-the-lowest eviction.
// ----------------------------------------------------------------------------
// Each item is one packet's 64-bit source key; each item gives exactly one
// result. The table is a row of TABLE_ENTRIES cells, each holding one key and
// its packet count. An accepted key is held while a search token walks down
// the row, one cell per cycle, collecting the matching entry or else the first
// entry with the lowest count. An item therefore passes through these steps
// before the next key is accepted: taking the key, letting the token cross
// the row, and writing the chosen cell. No new key is taken while one is
// still in the row. The result sits in an output register, so the
// next key is taken while a result still waits on out_stall; the write cycle
// waits only if the previous result has not yet been taken. Entries are
// filled in order, so only cells below the fill count take part in a search
// and the table needs no clearing after reset. Counts saturate at 2^32-1 and
// the packet total at 2^48-1. slot_index carries the low four bits of the
// slot number. TABLE_ENTRIES may range from 2 to 256.
// ----------------------------------------------------------------------------
`include "top_source_frequency_table_assert.svh"

module top_source_frequency_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] source_key,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  slot_index,
	output logic [1:0]  action,
	output logic [31:0] slot_count,
	output logic [63:0] evicted_key,
	output logic [31:0] evicted_count,
	output logic [47:0] packets_seen
);
	import sft_pkg::*;

	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int CW = $clog2(TABLE_ENTRIES);

	sft_state_t state_q, state_d;

	logic [CW-1:0]      scan_cnt_q;
	logic [UW-1:0]      used_q;
	logic [TOTAL_W-1:0] total_q;
	logic [KEY_W-1:0]   key_q;

	logic               scan_done;
	logic               commit_go;
	logic               in_take;

	sft_tok_t           chain [TABLE_ENTRIES+1];
	sft_tok_t           tok_last;
	sft_wr_t            wr;
	logic [SLOT_W:0]    used_ext;
	logic               table_full;

	// Decision for the current item.
	logic [SLOT_W-1:0]  slot_d;
	logic [ACT_W-1:0]   act_d;
	logic [CNT_W-1:0]   cnt_d;
	logic [KEY_W-1:0]   ev_key_d;
	logic [CNT_W-1:0]   ev_cnt_d;
	logic [TOTAL_W-1:0] total_d;

	// Output register.
	logic               out_valid_q;
	logic [3:0]         slot_index_q;
	logic [ACT_W-1:0]   action_q;
	logic [CNT_W-1:0]   slot_count_q;
	logic [KEY_W-1:0]   evicted_key_q;
	logic [CNT_W-1:0]   evicted_count_q;
	logic [TOTAL_W-1:0] packets_seen_q;

	assign used_ext   = (SLOT_W + 1)'(used_q);
	assign table_full = (used_q == UW'(TABLE_ENTRIES));
	assign scan_done  = (scan_cnt_q == CW'(TABLE_ENTRIES - 1));
	assign in_take    = in_valid && !in_stall;

	// ---- sequencer -------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_take) state_d = ST_SCAN;
			ST_SCAN:   if (scan_done) state_d = ST_COMMIT;
			ST_COMMIT: if (commit_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		commit_go = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SCAN:   in_stall = 1'b1;
			// Hold the commit while the previous result is still stalled.
			ST_COMMIT: commit_go = !out_valid_q || !out_stall;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end else begin
				scan_cnt_q <= '0;
			end
		end
	end

	// Hold the key for the whole search.
	always_ff @(posedge clk) begin
		if (in_take) begin
			key_q <= source_key;
		end
	end

	// ---- row of cells ----------------------------------------------------
	assign chain[0] = TOK_INIT;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		sft_cell u_cell (
			.clk       (clk),
			.probe_key (key_q),
			.cell_idx  (SLOT_W'(g)),
			.used      (used_ext),
			.wr        (wr),
			.tok_in    (chain[g]),
			.tok_out   (chain[g+1])
		);
	end

	assign tok_last = chain[TABLE_ENTRIES];

	// ---- decision --------------------------------------------------------
	always_comb begin
		ev_key_d = '0;
		ev_cnt_d = '0;
		if (tok_last.found) begin
			// Hit: bump the count, saturating.
			slot_d = tok_last.hit_idx;
			act_d  = ACT_HIT;
			cnt_d  = (tok_last.hit_cnt == CNT_MAX) ? CNT_MAX : tok_last.hit_cnt + 1'b1;
		end else if (!table_full) begin
			// Fill the next free slot.
			slot_d = used_ext[SLOT_W-1:0];
			act_d  = ACT_FILL;
			cnt_d  = CNT_W'(1);
		end else begin
			// Evict the first lowest-count entry.
			slot_d   = tok_last.min_idx;
			act_d    = ACT_REPLACE;
			cnt_d    = CNT_W'(1);
			ev_key_d = tok_last.min_key;
			ev_cnt_d = tok_last.min_cnt;
		end
	end

	assign total_d = (total_q == TOTAL_MAX) ? total_q : total_q + 1'b1;

	assign wr.en  = commit_go;
	assign wr.idx = slot_d;
	assign wr.key = key_q;
	assign wr.cnt = cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			total_q <= '0;
		end else if (commit_go) begin
			total_q <= total_d;
			if (!tok_last.found && !table_full) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	// ---- output register -------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			slot_index_q    <= slot_d[OUT_SLOT_W-1:0];
			action_q        <= act_d;
			slot_count_q    <= cnt_d;
			evicted_key_q   <= ev_key_d;
			evicted_count_q <= ev_cnt_d;
			packets_seen_q  <= total_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_index    = slot_index_q;
	assign action        = action_q;
	assign slot_count    = slot_count_q;
	assign evicted_key   = evicted_key_q;
	assign evicted_count = evicted_count_q;
	assign packets_seen  = packets_seen_q;

	// ---- checks ----------------------------------------------------------
	`SFT_ASSERT(a_used_bound, clk, arst_n, used_q <= UW'(TABLE_ENTRIES))
	`SFT_ASSERT(a_replace_when_full, clk, arst_n, !(commit_go && (act_d == ACT_REPLACE)) || table_full)
	`SFT_ASSERT_NEXT(a_commit_loads_out, clk, arst_n, commit_go, out_valid_q && (state_q == ST_IDLE))
	`SFT_ASSERT_NEXT(a_total_step, clk, arst_n, commit_go && (total_q != TOTAL_MAX), total_q == $past(total_q) + 1'b1)

endmodule
